@@ design/sdt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the signed truncating divider.
package sdt_pkg;

   // Default operand width.
   localparam int DATA_WIDTH_DEF = 32;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIX  = 3'b100
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture operands and start a new division
      logic step;    // one restoring shift-subtract iteration
      logic finish;  // apply signs and write the output registers
   } cmd_type;

endpackage

@@ design/sdt_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operands and results.
interface sdt_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend;
   logic signed [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sdt_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic signed [DATA_WIDTH-1:0] remainder;
   logic                         zero_divisor;
   logic                         overflow;

   modport source (output valid, output quotient, output remainder,
                   output zero_divisor, output overflow, input ready);
   modport sink   (input valid, input quotient, input remainder,
                   input zero_divisor, input overflow, output ready);
endinterface

@@ design/sdt_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: handshakes, iteration count and datapath commands.
module sdt_ctrl
   import sdt_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam int CNT_W = $clog2(DATA_WIDTH);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             last_step;
   logic             out_free;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign last_step = (cnt_ff == CNT_W'(DATA_WIDTH - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // Wait here until the output register can take the result.
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/sdt_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: magnitudes, restoring shift-subtract iteration, sign fixup, output register.
module sdt_datapath
   import sdt_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  cmd_type                      cmd,
   input  logic signed [DATA_WIDTH-1:0] dividend,
   input  logic signed [DATA_WIDTH-1:0] divisor,
   output logic signed [DATA_WIDTH-1:0] quotient,
   output logic signed [DATA_WIDTH-1:0] remainder,
   output logic                         zero_divisor,
   output logic                         overflow
);

   localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

   logic [DATA_WIDTH-1:0] n_raw, d_raw;
   logic [DATA_WIDTH-1:0] n_mag, d_mag;

   // The dividend register shifts left; quotient bits enter at the bottom,
   // so after the last step it holds the quotient magnitude.
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] d_ff, d_in;
   logic [DATA_WIDTH-1:0] r_ff, r_in;
   logic                  n_neg_ff, n_neg_in;
   logic                  d_neg_ff, d_neg_in;
   logic                  zero_ff, zero_in;
   logic                  ovf_ff, ovf_in;

   logic [DATA_WIDTH-1:0] quot_ff, quot_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic                  zero_out_ff, zero_out_in;
   logic                  ovf_out_ff, ovf_out_in;

   logic [DATA_WIDTH:0]   partial;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   assign n_raw = $unsigned(dividend);
   assign d_raw = $unsigned(divisor);
   assign n_mag = n_raw[DATA_WIDTH-1] ? (~n_raw + 1'b1) : n_raw;
   assign d_mag = d_raw[DATA_WIDTH-1] ? (~d_raw + 1'b1) : d_raw;

   // Partial remainder with the next dividend bit shifted in; one bit wider
   // so the bit shifted out of the top counts in the compare.
   assign partial = {r_ff, a_ff[DATA_WIDTH-1]};
   assign diff    = partial - {1'b0, d_ff};
   assign fits    = (partial >= {1'b0, d_ff});

   always_comb begin
      a_in        = a_ff;
      d_in        = d_ff;
      r_in        = r_ff;
      n_neg_in    = n_neg_ff;
      d_neg_in    = d_neg_ff;
      zero_in     = zero_ff;
      ovf_in      = ovf_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      zero_out_in = zero_out_ff;
      ovf_out_in  = ovf_out_ff;
      if (cmd.load) begin
         a_in     = n_mag;
         d_in     = d_mag;
         r_in     = '0;
         n_neg_in = n_raw[DATA_WIDTH-1];
         d_neg_in = d_raw[DATA_WIDTH-1];
         zero_in  = (d_raw == '0);
         ovf_in   = (n_raw == MOST_NEG) && (d_raw == ALL_ONES);
      end else if (cmd.step) begin
         a_in = {a_ff[DATA_WIDTH-2:0], fits};
         r_in = fits ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
      end
      if (cmd.finish) begin
         if (zero_ff) begin
            quot_in = '0;
            rem_in  = '0;
         end else begin
            quot_in = (n_neg_ff != d_neg_ff) ? (~a_ff + 1'b1) : a_ff;
            rem_in  = n_neg_ff ? (~r_ff + 1'b1) : r_ff;
         end
         zero_out_in = zero_ff;
         ovf_out_in  = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      d_ff        <= d_in;
      r_ff        <= r_in;
      n_neg_ff    <= n_neg_in;
      d_neg_ff    <= d_neg_in;
      zero_ff     <= zero_in;
      ovf_ff      <= ovf_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      zero_out_ff <= zero_out_in;
      ovf_out_ff  <= ovf_out_in;
   end

   assign quotient     = $signed(quot_ff);
   assign remainder    = $signed(rem_ff);
   assign zero_divisor = zero_out_ff;
   assign overflow     = ovf_out_ff;

endmodule

@@ design/signed_divider_truncating_unit.sv @@
`timescale 1ns / 1ps
// Top level of the signed truncating divider: controller, datapath and channel ports.
//
// This unit divides a signed DATA_WIDTH-bit dividend by a signed divisor and
// returns the quotient truncated toward zero and a remainder that carries the
// dividend's sign, exactly as C's / and % behave. Both operands are reduced to
// unsigned magnitudes, so the most negative dividend is handled without
// overflow. A zero divisor returns zero for both quotient and remainder and
// sets zero_divisor. The most negative value divided by minus one returns the
// most negative value as quotient, a zero remainder, and sets overflow. An
// operand transaction is loaded, then runs through the radix-2 restoring
// shift-subtract loop, which produces one quotient bit per cycle, and
// ends with a sign fixup step that writes the output register. The unit
// works on one transaction at a time. Because the result sits in its own
// output register, a new operand transaction is taken while the previous
// result still waits on the response channel; the fixup step holds only if
// that register is still occupied when the next result is ready.
module signed_divider_truncating_unit
   import sdt_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   sdt_req_if.sink   req_chan,
   sdt_rsp_if.source rsp_chan
);

   cmd_type cmd;

   // The controller sequences the load, the iteration loop and the fixup,
   // and owns both handshakes.
   sdt_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // The datapath holds the operands, the partial remainder and the result.
   sdt_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .dividend     (req_chan.dividend),
      .divisor      (req_chan.divisor),
      .quotient     (rsp_chan.quotient),
      .remainder    (rsp_chan.remainder),
      .zero_divisor (rsp_chan.zero_divisor),
      .overflow     (rsp_chan.overflow)
   );

   // A zero divisor and an overflow can never be reported together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.zero_divisor && rsp_chan.overflow))
      else $error("zero_divisor and overflow both set");

   // A zero divisor forces both results to zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.zero_divisor) |->
         (rsp_chan.quotient == '0 && rsp_chan.remainder == '0))
      else $error("divide by zero returned a nonzero result");

   // The overflow case wraps to the most negative value with no remainder.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.overflow) |->
         (rsp_chan.quotient == {1'b1, {(DATA_WIDTH-1){1'b0}}}
          && rsp_chan.remainder == '0))
      else $error("overflow result is not the most negative value");

   // After a transaction is accepted the unit is busy with the division.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("operand accepted while a division was in progress");

endmodule
